@@ rtl/core/tia_pkg.sv @@
// tia_pkg: shared constants, codes and types of the timestamp interval aggregator
// used by the interfaces' users, the command queue, the front and back ends and the top level
`default_nettype none

package tia_pkg;

	localparam int TABLE_ENTRIES = 32;
	localparam int TIMER_BITS    = 16;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
	localparam int QUEUE_DEPTH   = 2;
	localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

	// interval wraps at the timer width
	localparam logic [31:0] CHARGE_MASK = 32'((64'd1 << TIMER_BITS) - 64'd1);

	localparam logic [1:0] FUNC_STAMP = 2'd0;
	localparam logic [1:0] FUNC_CLEAR = 2'd1;
	localparam logic [1:0] FUNC_READ  = 2'd2;

	localparam logic [2:0] ST_NONE        = 3'd0;
	localparam logic [2:0] ST_NEW         = 3'd1;
	localparam logic [2:0] ST_UPDATED     = 3'd2;
	localparam logic [2:0] ST_FULL        = 3'd3;
	localparam logic [2:0] ST_CLEARED     = 3'd4;
	localparam logic [2:0] ST_READ_OK     = 3'd5;
	localparam logic [2:0] ST_READ_UNUSED = 3'd6;

	localparam logic REG_CATEGORY_MODE  = 1'b0;
	localparam logic REG_STAMP_OVERHEAD = 1'b1;

	typedef enum logic [2:0] {
		CMD_NOP,
		CMD_RUNSTART,
		CMD_STAMP,
		CMD_CLEAR,
		CMD_READ
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [15:0] key;
		logic [31:0] charge;
		logic [4:0]  index;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} q_entry_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [15:0]      key;
		logic [31:0]      time_acc;
		logic [15:0]      episodes;
		logic [CNT_W-1:0] used;
	} res_t;

endpackage

`default_nettype wire

@@ rtl/core/tia_ifs.sv @@
// tia_in_if and tia_out_if: valid/ready channels of the timestamp interval aggregator
// no dependencies
`default_nettype none

interface tia_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [15:0] stamp_key;
	logic [15:0] stamp_time;
	logic        run_start;
	logic [4:0]  read_index;

	modport source (output valid, func, stamp_key, stamp_time, run_start, read_index,
		input ready);
	modport sink (input valid, func, stamp_key, stamp_time, run_start, read_index,
		output ready);
endinterface

interface tia_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [15:0] entry_key;
	logic [31:0] entry_time;
	logic [15:0] entry_episodes;
	logic [5:0]  entries_used;

	modport source (output valid, status, entry_key, entry_time, entry_episodes, entries_used,
		input ready);
	modport sink (input valid, status, entry_key, entry_time, entry_episodes, entries_used,
		output ready);
endinterface

`default_nettype wire

@@ rtl/core/tia_cmd_queue.sv @@
// tia_cmd_queue: short command queue between the front and back ends
// depends on tia_pkg
`default_nettype none

module tia_cmd_queue import tia_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  q_entry_t push,
	input  logic     pop,
	output logic     full,
	output q_entry_t head
);

	cmd_t              slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.cmd   = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.valid) begin
			slots_q[wr_ptr_q] <= push.cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= QPTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= QPTR_W'(rd_ptr_q + 1'b1);
			end
			if (push.valid && !pop) begin
				count_q <= QCNT_W'(count_q + 1'b1);
			end else if (pop && !push.valid) begin
				count_q <= QCNT_W'(count_q - 1'b1);
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/tia_front.sv @@
// tia_front: accepts requests, tracks the previous stamp and turns each request into a command
// depends on tia_pkg and tia_in_if
`default_nettype none

module tia_front import tia_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	tia_in_if.sink      stamp,
	input  logic [15:0] stamp_overhead,
	input  logic        q_full,
	output q_entry_t    q_push
);

	logic [15:0] prev_key_q;
	logic [15:0] prev_time_q;
	logic        have_prev_q;
	logic        take;
	logic [31:0] diff;
	cmd_t        cmd;

	assign stamp.ready = !q_full;
	assign take        = stamp.valid && !q_full;

	assign diff = {16'd0, stamp.stamp_time} - {16'd0, prev_time_q} - {16'd0, stamp_overhead};

	always_comb begin
		cmd.kind   = CMD_NOP;
		cmd.key    = stamp.stamp_key;
		cmd.charge = diff & CHARGE_MASK;
		cmd.index  = stamp.read_index;
		case (stamp.func)
			FUNC_STAMP: begin
				// interval goes to the key of the earlier stamp
				cmd.kind = (stamp.run_start || !have_prev_q) ? CMD_RUNSTART : CMD_STAMP;
				cmd.key  = prev_key_q;
			end
			FUNC_CLEAR: cmd.kind = CMD_CLEAR;
			FUNC_READ:  cmd.kind = CMD_READ;
			default:    cmd.kind = CMD_NOP;
		endcase
	end

	assign q_push.valid = take;
	assign q_push.cmd   = cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_key_q  <= '0;
			prev_time_q <= '0;
			have_prev_q <= 1'b0;
		end else if (take && stamp.func == FUNC_STAMP) begin
			prev_key_q  <= stamp.stamp_key;
			prev_time_q <= stamp.stamp_time;
			have_prev_q <= 1'b1;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/tia_back.sv @@
// tia_back: executes commands against the key table and the time and episode memories
// depends on tia_pkg and tia_out_if
`default_nettype none

module tia_back import tia_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     category_mode,
	input  q_entry_t q_head,
	output logic     q_pop,
	tia_out_if.source result
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_LOOK   = 5'b00010,
		S_FETCH  = 5'b00100,
		S_FINISH = 5'b01000,
		S_SWEEP  = 5'b10000
	} state_t;

	state_t            state_q;
	state_t            state_d;
	cmd_t              cmd_q;
	logic              hit_q;
	logic              hit_d;
	logic [IDX_W-1:0]  addr_q;
	logic [IDX_W-1:0]  addr_d;
	logic [CNT_W-1:0]  used_q;
	logic [CNT_W-1:0]  used_d;
	logic              counted_q [TABLE_ENTRIES];
	logic [15:0]       keys_q [TABLE_ENTRIES];
	logic [31:0]       time_mem [TABLE_ENTRIES];
	logic [15:0]       ep_mem [TABLE_ENTRIES];
	logic [31:0]       rd_time_q;
	logic [15:0]       rd_ep_q;
	logic              out_valid_q;
	res_t              out_q;

	logic              out_free;
	logic              hit_any;
	logic [IDX_W-1:0]  hit_idx;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_wa;
	logic [31:0]       mem_wtime;
	logic [15:0]       mem_wep;
	logic              key_we;
	logic              cnt_set;
	logic              cnt_clr_all;
	logic              used_inc;
	logic              emit;
	res_t              res;
	logic [CNT_W-1:0]  addr_next;

	assign out_free = !out_valid_q || result.ready;
	assign q_pop    = (state_q == S_IDLE) && q_head.valid && out_free;

	// lowest occupied entry holding the charged key
	always_comb begin
		hit_any = 1'b0;
		hit_idx = '0;
		for (int e = TABLE_ENTRIES - 1; e >= 0; e--) begin
			if (keys_q[e] == cmd_q.key && CNT_W'(e) < used_q) begin
				hit_any = 1'b1;
				hit_idx = IDX_W'(e);
			end
		end
	end

	assign addr_next = CNT_W'(CNT_W'(addr_q) + CNT_W'(1));
	assign used_d    = CNT_W'(used_q + CNT_W'(used_inc));

	always_comb begin
		state_d     = state_q;
		hit_d       = hit_q;
		addr_d      = addr_q;
		mem_we      = 1'b0;
		mem_wa      = addr_q;
		mem_wtime   = '0;
		mem_wep     = '0;
		key_we      = 1'b0;
		cnt_set     = 1'b0;
		cnt_clr_all = 1'b0;
		used_inc    = 1'b0;
		emit        = 1'b0;
		res.status  = ST_NONE;
		res.key     = '0;
		res.time_acc = '0;
		res.episodes = '0;
		case (state_q)
			S_IDLE: begin
				if (q_pop) begin
					state_d = S_LOOK;
				end
			end
			S_LOOK: begin
				case (cmd_q.kind)
					CMD_STAMP: begin
						hit_d   = hit_any;
						addr_d  = hit_idx;
						state_d = S_FETCH;
					end
					CMD_READ: begin
						hit_d   = 32'(cmd_q.index) < 32'(used_q);
						addr_d  = IDX_W'(cmd_q.index);
						state_d = S_FETCH;
					end
					CMD_CLEAR: begin
						addr_d = '0;
						if (used_q == '0) begin
							emit       = 1'b1;
							res.status = ST_CLEARED;
							state_d    = S_IDLE;
						end else begin
							state_d = S_SWEEP;
						end
					end
					CMD_RUNSTART: begin
						cnt_clr_all = 1'b1;
						emit        = 1'b1;
						state_d     = S_IDLE;
					end
					default: begin
						emit    = 1'b1;
						state_d = S_IDLE;
					end
				endcase
			end
			S_FETCH: begin
				// memories read at addr_q this cycle
				state_d = S_FINISH;
			end
			S_FINISH: begin
				emit    = 1'b1;
				state_d = S_IDLE;
				case (cmd_q.kind)
					CMD_STAMP: begin
						res.key = cmd_q.key;
						if (hit_q) begin
							mem_we    = 1'b1;
							cnt_set   = 1'b1;
							mem_wtime = rd_time_q + cmd_q.charge;
							mem_wep   = (!category_mode || !counted_q[addr_q]) ?
								16'(rd_ep_q + 16'd1) : rd_ep_q;
							res.status   = ST_UPDATED;
							res.time_acc = mem_wtime;
							res.episodes = mem_wep;
						end else if (used_q == CNT_W'(TABLE_ENTRIES)) begin
							res.status = ST_FULL;
						end else begin
							mem_wa       = IDX_W'(used_q);
							mem_we       = 1'b1;
							key_we       = 1'b1;
							cnt_set      = 1'b1;
							used_inc     = 1'b1;
							mem_wtime    = cmd_q.charge;
							mem_wep      = 16'd1;
							res.status   = ST_NEW;
							res.time_acc = cmd_q.charge;
							res.episodes = 16'd1;
						end
					end
					CMD_READ: begin
						if (hit_q) begin
							res.status   = ST_READ_OK;
							res.key      = keys_q[addr_q];
							res.time_acc = rd_time_q;
							res.episodes = rd_ep_q;
						end else begin
							res.status = ST_READ_UNUSED;
						end
					end
					default: res.status = ST_NONE;
				endcase
			end
			S_SWEEP: begin
				mem_we = 1'b1;
				if (addr_next == used_q) begin
					emit       = 1'b1;
					res.status = ST_CLEARED;
					state_d    = S_IDLE;
				end else begin
					addr_d = IDX_W'(addr_next);
				end
			end
			default: state_d = S_IDLE;
		endcase
		res.used = used_d;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			time_mem[mem_wa] <= mem_wtime;
			ep_mem[mem_wa]   <= mem_wep;
		end
		rd_time_q <= time_mem[addr_q];
		rd_ep_q   <= ep_mem[addr_q];
	end

	always_ff @(posedge clk) begin
		if (key_we) begin
			keys_q[mem_wa] <= cmd_q.key;
		end
		if (q_pop) begin
			cmd_q <= q_head.cmd;
		end
		hit_q  <= hit_d;
		addr_q <= addr_d;
		if (emit) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			out_valid_q <= 1'b0;
			for (int e = 0; e < TABLE_ENTRIES; e++) begin
				counted_q[e] <= 1'b0;
			end
		end else begin
			state_q <= state_d;
			used_q  <= used_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cnt_clr_all) begin
				for (int e = 0; e < TABLE_ENTRIES; e++) begin
					counted_q[e] <= 1'b0;
				end
			end else if (cnt_set) begin
				counted_q[mem_wa] <= 1'b1;
			end
		end
	end

	assign result.valid          = out_valid_q;
	assign result.status         = out_q.status;
	assign result.entry_key      = out_q.key;
	assign result.entry_time     = out_q.time_acc;
	assign result.entry_episodes = out_q.episodes;
	assign result.entries_used   = 6'(out_q.used);

endmodule

`default_nettype wire

@@ rtl/core/timestamp_interval_aggregator.sv @@
// timestamp_interval_aggregator: top level with the configuration registers
// depends on tia_pkg, tia_ifs, tia_cmd_queue, tia_front and tia_back
//
// Requests enter on the stamp channel (valid/ready): a timestamp event, a clear
// of all counters or a read of one table entry. Every request gives exactly one
// result on the result channel, in request order. A timestamp charges the time
// since the previous stamp, less the configured overhead, to the previous key.
// Configuration goes through the APB port: register 0 (byte 0) is category_mode,
// register 1 (byte 4) is stamp_overhead; write them only while the block is idle.
// A charged timestamp or a read passes the key lookup (an index check for a read), the
// time and episode memory read and, for a timestamp, the write-back, and its result
// is then registered; the back end takes a new command only once it is idle again.
// A run-start stamp or an unknown request ends in the lookup state. A clear walks the
// occupied entries, one per cycle.
// A two-entry command queue lets the front keep accepting while a result waits
// on a stalled receiver; once the queue fills, stamp.ready drops.
// Reset clears the entry count, run marks, previous stamp and configuration;
// no clearing pass runs, so requests are accepted right after reset.
`default_nettype none

module timestamp_interval_aggregator import tia_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	tia_in_if.sink      stamp,
	tia_out_if.source   result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic        category_mode_q;
	logic [15:0] stamp_overhead_q;
	logic        cfg_wr;
	logic        q_full;
	logic        q_pop;
	q_entry_t    q_push;
	q_entry_t    q_head;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			category_mode_q  <= 1'b0;
			stamp_overhead_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_CATEGORY_MODE:  category_mode_q  <= pwdata[0];
				REG_STAMP_OVERHEAD: stamp_overhead_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_CATEGORY_MODE:  prdata = {31'd0, category_mode_q};
			REG_STAMP_OVERHEAD: prdata = {16'd0, stamp_overhead_q};
			default:            prdata = '0;
		endcase
	end

	tia_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.stamp          (stamp),
		.stamp_overhead (stamp_overhead_q),
		.q_full         (q_full),
		.q_push         (q_push)
	);

	tia_cmd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.pop    (q_pop),
		.full   (q_full),
		.head   (q_head)
	);

	tia_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.category_mode (category_mode_q),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.result        (result)
	);

endmodule

`default_nettype wire
